// ===== rtl/tree_distance_lca_query_defines.svh =====
// Assertion macros shared by the tree distance query block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TREE_DISTANCE_LCA_QUERY_DEFINES_SVH
`define TREE_DISTANCE_LCA_QUERY_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TDLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdlq: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TDLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdlq: next-cycle check failed");

`endif

// ===== rtl/tdlq_pkg.sv =====
// Shared widths, codes and ALU request types for the tree distance query block.
// No dependencies; imported by tdlq_alu and tree_distance_lca_query.
package tdlq_pkg;

    localparam int NODE_W   = 12;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [DIST_W-1:0]   lhs;
        logic [DIST_W-1:0]   rhs;
    } t_alu_req;

    typedef struct packed {
        logic [DIST_W-1:0]   result;
        logic                borrow;
    } t_alu_rsp;

endpackage

// ===== rtl/tree_distance_lca_query.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | i_in_valid / o_in_ready    | i_mode, i_node_a, i_node_b, i_edge_weight
// output   | o_out_valid / i_out_ready  | o_path_length, o_error
//
// A load writes the new node's root distance and parent, then fills each further
// ancestor row entry with one read of the row named by the entry before it and one
// write, through the table's write port and first read port, then writes the depth.
// A query fetches, compares depths (with a swap step when the first node is the
// shallower one), lifts one step per 2^(LEVELS-1) block of the depth gap and one per
// set bit of the rest, makes a final lift check, seeks the common ancestor when the
// lifted nodes differ and forms the three distance sums in the shared adder.
// After reset a clearing pass over min(NODES,4096) nodes marks only the root loaded;
// no transfer is accepted then. The finished result sits in an output register, so a
// stalled output side holds only the next finishing item.
// Depends on tdlq_pkg, tdlq_alu and tree_distance_lca_query_defines.svh.
`include "tree_distance_lca_query_defines.svh"

module tree_distance_lca_query #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [tdlq_pkg::NODE_W-1:0]     i_node_a,
    input  logic [tdlq_pkg::NODE_W-1:0]     i_node_b,
    input  logic [tdlq_pkg::WEIGHT_W-1:0]   i_edge_weight,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tdlq_pkg::DIST_W-1:0]     o_path_length,
    output logic                            o_error
);
    import tdlq_pkg::*;

    // Node fields are 12 bits, so storage never exceeds 4096 nodes.
    localparam int DEPTH     = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int IW        = $clog2(DEPTH);
    localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int KW        = $clog2(LEVELS + 1);
    localparam int AAW       = IW + LW;
    localparam int ANC_DEPTH = DEPTH << LW;
    localparam int TOPSTEP   = 1 << (LEVELS - 1);
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);
    localparam logic [KW-1:0] LVL_END = KW'(LEVELS);

    typedef enum logic [18:0] {
        S_CLEAR  = 19'h00001,
        S_IDLE   = 19'h00002,
        S_FETCH  = 19'h00004,
        S_CHECK  = 19'h00008,
        S_SWAP   = 19'h00010,
        S_LREQ   = 19'h00020,
        S_LWR    = 19'h00040,
        S_LDEP   = 19'h00080,
        S_LIFT   = 19'h00100,
        S_LIFTW  = 19'h00200,
        S_LCAREQ = 19'h00400,
        S_LCACMP = 19'h00800,
        S_PARREQ = 19'h01000,
        S_PARW   = 19'h02000,
        S_DREQ   = 19'h04000,
        S_SUM1   = 19'h08000,
        S_SUM2   = 19'h10000,
        S_SUM3   = 19'h20000,
        S_DONE   = 19'h40000
    } t_state;

    function automatic logic [LW-1:0] lsb_index(input logic [IW-1:0] d);
        logic [LW-1:0] idx;
        idx = '0;
        for (int i = IW - 1; i >= 0; i--) begin
            if (d[i]) begin
                idx = LW'(i);
            end
        end
        return idx;
    endfunction

    // Storage
    logic              r_loaded_mem [DEPTH];
    logic [IW-1:0]     r_depth_mem  [DEPTH];
    logic [DIST_W-1:0] r_dist_mem   [DEPTH];
    logic [IW-1:0]     r_anc_mem    [ANC_DEPTH];

    // Control and working registers
    t_state            r_state, n_state;
    logic [IW-1:0]     r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    logic              r_mode, n_mode;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic [WEIGHT_W-1:0] r_w, n_w;
    logic [KW-1:0]     r_k, n_k;
    logic [LW-1:0]     r_j, n_j;
    logic [IW-1:0]     r_cur, n_cur, r_u, n_u, r_v, n_v, r_lca, n_lca, r_diff, n_diff;
    logic [DIST_W-1:0] r_dist_a, n_dist_a, r_dist_b, n_dist_b;
    logic [DIST_W-1:0] r_dl, n_dl, r_acc, n_acc, r_res_len, n_res_len;
    logic              r_res_err, n_res_err;
    logic [DIST_W-1:0] r_out_len;
    logic              r_out_err;

    // Registered read data
    logic              r_ld_qa, r_ld_qb;
    logic [IW-1:0]     r_dep_qa, r_dep_qb;
    logic [DIST_W-1:0] r_dist_qa, r_dist_qb;
    logic [IW-1:0]     r_anc_qa_raw, r_anc_qb_raw;
    logic              r_anc_root_a, r_anc_root_b;

    // Port controls
    logic              ld_we, ld_wd;
    logic [IW-1:0]     ld_wa;
    logic              dep_we;
    logic [IW-1:0]     dep_wa, dep_wd;
    logic              dist_we;
    logic [IW-1:0]     dist_wa, dist_ra;
    logic [DIST_W-1:0] dist_wd;
    logic              anc_we;
    logic [AAW-1:0]    anc_wa;
    logic [IW-1:0]     anc_wd;
    logic [IW-1:0]     anc_node_a;
    logic [LW-1:0]     anc_lvl_a;
    logic [IW-1:0]     anc_qa, anc_qb;

    logic [IW-1:0]     a_idx, b_idx;
    logic              a_ok, b_ok, load_err, query_err;
    logic [LW-1:0]     lift_lvl;
    logic [KW-1:0]     k_prev;
    logic              done_fire;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    tdlq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign a_idx     = r_a[IW-1:0];
    assign b_idx     = r_b[IW-1:0];
    assign a_ok      = 32'(r_a) < 32'(DEPTH);
    assign b_ok      = 32'(r_b) < 32'(DEPTH);
    assign load_err  = !a_ok || !b_ok || !r_ld_qb || r_ld_qa;
    assign query_err = !a_ok || !b_ok || !r_ld_qa || !r_ld_qb;
    assign k_prev    = r_k - KW'(1);

    // The root row points to the root; read it as zero instead of storing it.
    assign anc_qa    = r_anc_root_a ? '0 : r_anc_qa_raw;
    assign anc_qb    = r_anc_root_b ? '0 : r_anc_qb_raw;

    // Take a full 2^(LEVELS-1) step while the gap allows, else clear the lowest bit.
    assign lift_lvl  = alu_rsp.borrow ? lsb_index(r_diff) : LVL_TOP;
    assign dist_ra   = (r_state == S_DREQ) ? r_lca : a_idx;

    always_comb begin
        unique case (r_state)
            S_LREQ:   begin anc_node_a = r_cur; anc_lvl_a = k_prev[LW-1:0]; end
            S_LIFT:   begin anc_node_a = r_u;   anc_lvl_a = lift_lvl;       end
            S_LCAREQ: begin anc_node_a = r_u;   anc_lvl_a = r_j;            end
            default:  begin anc_node_a = r_u;   anc_lvl_a = '0;             end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_w         = r_w;
        n_k         = r_k;
        n_j         = r_j;
        n_cur       = r_cur;
        n_u         = r_u;
        n_v         = r_v;
        n_lca       = r_lca;
        n_diff      = r_diff;
        n_dist_a    = r_dist_a;
        n_dist_b    = r_dist_b;
        n_dl        = r_dl;
        n_acc       = r_acc;
        n_res_len   = r_res_len;
        n_res_err   = r_res_err;
        done_fire   = 1'b0;
        alu_req.op  = ALU_ADD;
        alu_req.lhs = '0;
        alu_req.rhs = '0;
        ld_we       = 1'b0;
        ld_wa       = a_idx;
        ld_wd       = 1'b1;
        dep_we      = 1'b0;
        dep_wa      = a_idx;
        dep_wd      = '0;
        dist_we     = 1'b0;
        dist_wa     = a_idx;
        dist_wd     = '0;
        anc_we      = 1'b0;
        anc_wa      = {a_idx, LW'(0)};
        anc_wd      = b_idx;

        unique case (r_state)
            S_CLEAR: begin
                ld_we   = 1'b1;
                ld_wa   = r_clr;
                ld_wd   = (r_clr == '0);
                dep_we  = 1'b1;
                dep_wa  = r_clr;
                dist_we = 1'b1;
                dist_wa = r_clr;
                n_clr   = r_clr + IW'(1);
                if (r_clr == IW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_w     = i_edge_weight;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_mode == MODE_LOAD) begin
                    if (load_err) begin
                        n_res_len = '0;
                        n_res_err = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        alu_req.op  = ALU_ADD;
                        alu_req.lhs = r_dist_qb;
                        alu_req.rhs = 32'(r_w);
                        dist_we     = 1'b1;
                        dist_wd     = alu_rsp.result;
                        anc_we      = 1'b1;
                        n_k         = KW'(1);
                        n_cur       = b_idx;
                        n_state     = S_LREQ;
                    end
                end else begin
                    if (query_err) begin
                        n_res_len = '0;
                        n_res_err = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        alu_req.op  = ALU_SUB;
                        alu_req.lhs = 32'(r_dep_qa);
                        alu_req.rhs = 32'(r_dep_qb);
                        n_dist_a    = r_dist_qa;
                        n_dist_b    = r_dist_qb;
                        if (alu_rsp.borrow) begin
                            n_u     = b_idx;
                            n_v     = a_idx;
                            n_state = S_SWAP;
                        end else begin
                            n_u     = a_idx;
                            n_v     = b_idx;
                            n_diff  = alu_rsp.result[IW-1:0];
                            n_state = S_LIFT;
                        end
                    end
                end
            end
            S_SWAP: begin
                alu_req.op  = ALU_SUB;
                alu_req.lhs = 32'(r_dep_qb);
                alu_req.rhs = 32'(r_dep_qa);
                n_diff      = alu_rsp.result[IW-1:0];
                n_state     = S_LIFT;
            end
            S_LREQ: begin
                n_state = (r_k == LVL_END) ? S_LDEP : S_LWR;
            end
            S_LWR: begin
                anc_we  = 1'b1;
                anc_wa  = {a_idx, r_k[LW-1:0]};
                anc_wd  = anc_qa;
                n_cur   = anc_qa;
                n_k     = r_k + KW'(1);
                n_state = S_LREQ;
            end
            S_LDEP: begin
                alu_req.op  = ALU_ADD;
                alu_req.lhs = 32'(r_dep_qb);
                alu_req.rhs = 32'd1;
                dep_we      = 1'b1;
                dep_wd      = alu_rsp.result[IW-1:0];
                ld_we       = 1'b1;
                n_res_len   = '0;
                n_res_err   = 1'b0;
                n_state     = S_DONE;
            end
            S_LIFT: begin
                alu_req.op  = ALU_SUB;
                alu_req.lhs = 32'(r_diff);
                alu_req.rhs = 32'(TOPSTEP);
                if (r_diff == '0) begin
                    if (r_u == r_v) begin
                        n_lca   = r_u;
                        n_state = S_DREQ;
                    end else begin
                        n_j     = LVL_TOP;
                        n_state = S_LCAREQ;
                    end
                end else begin
                    if (!alu_rsp.borrow) begin
                        n_diff = alu_rsp.result[IW-1:0];
                    end else begin
                        n_diff = r_diff & ~(IW'(1) << lift_lvl);
                    end
                    n_state = S_LIFTW;
                end
            end
            S_LIFTW: begin
                n_u     = anc_qa;
                n_state = S_LIFT;
            end
            S_LCAREQ: begin
                n_state = S_LCACMP;
            end
            S_LCACMP: begin
                if (anc_qa != anc_qb) begin
                    n_u = anc_qa;
                    n_v = anc_qb;
                end
                if (r_j == '0) begin
                    n_state = S_PARREQ;
                end else begin
                    n_j     = r_j - LW'(1);
                    n_state = S_LCAREQ;
                end
            end
            S_PARREQ: begin
                n_state = S_PARW;
            end
            S_PARW: begin
                n_lca   = anc_qa;
                n_state = S_DREQ;
            end
            S_DREQ: begin
                n_state = S_SUM1;
            end
            S_SUM1: begin
                alu_req.op  = ALU_ADD;
                alu_req.lhs = r_dist_a;
                alu_req.rhs = r_dist_b;
                n_acc       = alu_rsp.result;
                n_dl        = r_dist_qa;
                n_state     = S_SUM2;
            end
            S_SUM2: begin
                alu_req.op  = ALU_SUB;
                alu_req.lhs = r_acc;
                alu_req.rhs = r_dl;
                n_acc       = alu_rsp.result;
                n_state     = S_SUM3;
            end
            S_SUM3: begin
                alu_req.op  = ALU_SUB;
                alu_req.lhs = r_acc;
                alu_req.rhs = r_dl;
                n_res_len   = alu_rsp.result;
                n_res_err   = 1'b0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free or drains this cycle.
                if (!r_out_valid || i_out_ready) begin
                    done_fire = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (done_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_a       <= n_a;
        r_b       <= n_b;
        r_w       <= n_w;
        r_k       <= n_k;
        r_j       <= n_j;
        r_cur     <= n_cur;
        r_u       <= n_u;
        r_v       <= n_v;
        r_lca     <= n_lca;
        r_diff    <= n_diff;
        r_dist_a  <= n_dist_a;
        r_dist_b  <= n_dist_b;
        r_dl      <= n_dl;
        r_acc     <= n_acc;
        r_res_len <= n_res_len;
        r_res_err <= n_res_err;
        if (done_fire) begin
            r_out_len <= r_res_len;
            r_out_err <= r_res_err;
        end
    end

    // Loaded flags, depth and root distance: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            r_loaded_mem[ld_wa] <= ld_wd;
        end
        if (dep_we) begin
            r_depth_mem[dep_wa] <= dep_wd;
        end
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
        end
        r_ld_qa   <= r_loaded_mem[a_idx];
        r_ld_qb   <= r_loaded_mem[b_idx];
        r_dep_qa  <= r_depth_mem[a_idx];
        r_dep_qb  <= r_depth_mem[b_idx];
        r_dist_qa <= r_dist_mem[dist_ra];
        r_dist_qb <= r_dist_mem[b_idx];
    end

    // Ancestor table, row per node, 2^LW slots per row.
    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anc_mem[anc_wa] <= anc_wd;
        end
        r_anc_qa_raw <= r_anc_mem[{anc_node_a, anc_lvl_a}];
        r_anc_qb_raw <= r_anc_mem[{r_v, r_j}];
        r_anc_root_a <= (anc_node_a == '0);
        r_anc_root_b <= (r_v == '0);
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_path_length = r_out_len;
    assign o_error       = r_out_err;

    `TDLQ_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `TDLQ_ASSERT_NOW(a_error_zero_len, i_clk, i_rst_n, o_out_valid && o_error, o_path_length == '0)
    `TDLQ_ASSERT_NOW(a_load_zero_len, i_clk, i_rst_n, (r_state == S_DONE) && (r_mode == MODE_LOAD), r_res_len == '0)

endmodule

// ===== rtl/tdlq_alu.sv =====
// Shared 32-bit add/subtract unit; the borrow doubles as a magnitude compare.
// Depends on tdlq_pkg.
module tdlq_alu (
    input  tdlq_pkg::t_alu_req i_req,
    output tdlq_pkg::t_alu_rsp o_rsp
);
    import tdlq_pkg::*;

    logic [DIST_W:0] w_sum;

    always_comb begin
        unique case (i_req.op)
            ALU_SUB: w_sum = {1'b0, i_req.lhs} - {1'b0, i_req.rhs};
            default: w_sum = {1'b0, i_req.lhs} + {1'b0, i_req.rhs};
        endcase
    end

    assign o_rsp.result = w_sum[DIST_W-1:0];
    assign o_rsp.borrow = (i_req.op == ALU_SUB) ? w_sum[DIST_W] : 1'b0;

endmodule
